// ===== sv/fixed_width_bit_unpacker_assert.svh =====
// ----------------------------------------------------------------------------
// fixed_width_bit_unpacker_assert.svh
// assertion macros used by the unpacker back end
// ----------------------------------------------------------------------------
`ifndef FIXED_WIDTH_BIT_UNPACKER_ASSERT_SVH
`define FIXED_WIDTH_BIT_UNPACKER_ASSERT_SVH

// condition holds at every edge out of reset
`define FWBU_ASSERT_NOW(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define FWBU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define FWBU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/fwbu_pkg.sv =====
// ----------------------------------------------------------------------------
// fwbu_pkg
// types, codes and helpers of the fixed-width bit unpacker
// ----------------------------------------------------------------------------
package fwbu_pkg;

	localparam int VALUE_W     = 64;
	localparam int WIN_W       = 72;
	localparam int BPV_W       = 7;
	localparam int VC_W        = 24;
	localparam int CFG_W       = 24;
	localparam int REG_IDX_W   = 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int DRAIN_W     = 3;

	// operation codes on the input port
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_DATA  = 2'd1;
	localparam logic [1:0] OP_PAD   = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_BPV = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_VC  = 1'b1;

	localparam logic [BPV_W-1:0]   BPV_RESET = 7'd8;
	localparam logic [BPV_W-1:0]   WIDTH_MAX = 7'd64;
	localparam logic [BPV_W-1:0]   BYTE_BITS = 7'd8;
	localparam logic [DRAIN_W-1:0] DRAIN_LAST = 3'd7;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_PAD   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               padded;
		logic               last_value;
	} res_t;

	typedef struct packed {
		logic [BPV_W-1:0] bits_per_value;
		logic [VC_W-1:0]  value_count;
	} cfg_t;

	// low w bits set, all ones from 64 up
	function automatic logic [VALUE_W-1:0] width_mask(input logic [BPV_W-1:0] w);
		logic [VALUE_W-1:0] m;
		if (w >= WIDTH_MAX) begin
			m = '1;
		end else begin
			m = ~({VALUE_W{1'b1}} << w[5:0]);
		end
		return m;
	endfunction

endpackage

// ===== sv/fwbu_fifo.sv =====
// ----------------------------------------------------------------------------
// fwbu_fifo
// two-entry queue with push/full and pop/empty handshakes
// ----------------------------------------------------------------------------
module fwbu_fifo
	import fwbu_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/fwbu_front.sv =====
// ----------------------------------------------------------------------------
// fwbu_front
// input side: accepts operations and turns them into back-end commands
// ----------------------------------------------------------------------------
module fwbu_front
	import fwbu_pkg::*;
(
	input  logic       push,
	input  logic [1:0] operation,
	input  logic [7:0] data_byte,
	output logic       full,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	logic keep;

	always_comb begin
		keep       = 1'b1;
		q_cmd.kind = CMD_START;
		unique case (operation)
			OP_START: q_cmd.kind = CMD_START;
			OP_DATA:  q_cmd.kind = CMD_DATA;
			OP_PAD:   q_cmd.kind = CMD_PAD;
			// unused code: the beat is taken and dropped
			default:  keep = 1'b0;
		endcase
	end

	assign q_cmd.data_byte = data_byte;
	assign full            = q_full;
	assign q_push          = push && !q_full && keep;

endmodule

// ===== sv/fwbu_back.sv =====
// ----------------------------------------------------------------------------
// fwbu_back
// execution side: bit window, value extraction and field counting
// ----------------------------------------------------------------------------
`include "fixed_width_bit_unpacker_assert.svh"

module fwbu_back
	import fwbu_pkg::*;
#(
	parameter int COUNT_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic cmd_empty,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res
);

	localparam int CW = (COUNT_BITS > VC_W) ? COUNT_BITS : VC_W;

	// held count gets one spare bit while a byte drains, cleared before the next byte
	logic [WIN_W-1:0]      win_q;
	logic [BPV_W:0]        held_q;
	logic [COUNT_BITS-1:0] emitted_q;
	logic                  draining_q;
	logic [DRAIN_W-1:0]    drain_cnt_q;

	logic [CW-1:0]         cnt_ext;
	logic [COUNT_BITS-1:0] cnt;
	logic [COUNT_BITS-1:0] emitted_inc;
	logic [BPV_W-1:0]      w;
	logic [BPV_W:0]        w_ext;
	logic [BPV_W:0]        held_base;
	logic [BPV_W:0]        pos;
	logic [WIN_W-1:0]      shifted;
	logic                  below;
	logic                  drain_go;

	logic [WIN_W-1:0]      win_d;
	logic [BPV_W:0]        held_d;
	logic [COUNT_BITS-1:0] emitted_d;
	logic                  draining_d;
	logic [DRAIN_W-1:0]    drain_cnt_d;

	assign cnt_ext     = CW'(cfg.value_count);
	assign cnt         = cnt_ext[COUNT_BITS-1:0];
	assign w           = (cfg.bits_per_value > WIDTH_MAX) ? WIDTH_MAX : cfg.bits_per_value;
	assign w_ext       = {1'b0, w};
	assign held_base   = {1'b0, held_q[BPV_W-1:0]};
	assign below       = (emitted_q < cnt);
	assign emitted_inc = emitted_q + 1'b1;
	assign pos         = held_q - w_ext;
	// positions past the low 64 bits see only the top byte, shifted by the low three bits
	assign shifted     = (pos >= {1'b0, WIDTH_MAX})
		? {{(WIN_W-8){1'b0}}, (win_q[WIN_W-1:VALUE_W] >> pos[2:0])}
		: (win_q >> pos[5:0]);
	assign drain_go    = draining_q && (held_q >= w_ext) && below;

	always_comb begin
		win_d       = win_q;
		held_d      = held_q;
		emitted_d   = emitted_q;
		draining_d  = draining_q;
		drain_cnt_d = drain_cnt_q;
		cmd_pop     = 1'b0;
		res_push    = 1'b0;
		res.value      = shifted[VALUE_W-1:0] & width_mask(w);
		res.padded     = 1'b0;
		res.last_value = (emitted_inc == cnt);

		if (drain_go) begin
			// one completed value per cycle while the result queue has room, oldest first
			if (!res_full) begin
				res_push    = 1'b1;
				held_d      = pos;
				emitted_d   = emitted_inc;
				drain_cnt_d = drain_cnt_q + 1'b1;
				if (drain_cnt_q == DRAIN_LAST) begin
					draining_d = 1'b0;
				end
			end
		end else begin
			draining_d = 1'b0;
			if (!cmd_empty) begin
				unique case (cmd.kind)
					CMD_START: begin
						cmd_pop   = 1'b1;
						win_d     = '0;
						held_d    = '0;
						emitted_d = '0;
					end
					CMD_PAD: begin
						if (!below) begin
							cmd_pop = 1'b1;
						end else if (!res_full) begin
							cmd_pop    = 1'b1;
							res_push   = 1'b1;
							res.value  = '0;
							res.padded = 1'b1;
							emitted_d  = emitted_inc;
						end
					end
					CMD_DATA: begin
						cmd_pop = 1'b1;
						if (below && (w != '0)) begin
							win_d       = {win_q[WIN_W-9:0], cmd.data_byte};
							held_d      = held_base + {1'b0, BYTE_BITS};
							draining_d  = 1'b1;
							drain_cnt_d = '0;
						end
					end
					default: begin
						cmd_pop = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			held_q      <= '0;
			emitted_q   <= '0;
			draining_q  <= 1'b0;
			drain_cnt_q <= '0;
		end else begin
			win_q       <= win_d;
			held_q      <= held_d;
			emitted_q   <= emitted_d;
			draining_q  <= draining_d;
			drain_cnt_q <= drain_cnt_d;
		end
	end

	`FWBU_ASSERT_IMP(a_no_emit_past_count, clk, arst_n, res_push, below, "value emitted past count")
	`FWBU_ASSERT_NXT(a_emit_counts, clk, arst_n, res_push, emitted_q == $past(emitted_inc), "emit count slip")
	`FWBU_ASSERT_NXT(a_drain_limit, clk, arst_n, res_push && !res.padded && (drain_cnt_q == DRAIN_LAST), !draining_q, "drain ran past eight beats")
	`FWBU_ASSERT_NXT(a_start_clears, clk, arst_n, cmd_pop && (cmd.kind == CMD_START), held_q == '0 && emitted_q == '0, "start did not clear state")

endmodule

// ===== sv/fixed_width_bit_unpacker.sv =====
// A big-endian byte stream goes in as operations (start, data byte, pad) and
// unsigned values of bits_per_value bits (0..64) come out, up to value_count
// per field, the final one flagged by last_value. The input side takes one
// operation per cycle into a two-entry command queue while that queue is not
// full; the execution side then handles a start or a pad directly, and shifts
// a data byte into the 72-bit window before it extracts the values that the
// byte completes one at a time (at most eight, for width 1). The next command
// is not taken until that per-value extraction loop is done, so narrow values
// slow the byte rate. Results wait in a two-entry output queue. There is
// no clearing pass after reset.
// ----------------------------------------------------------------------------
// fixed_width_bit_unpacker
// top level: config registers, front end, command queue, back end, result queue
// ----------------------------------------------------------------------------
module fixed_width_bit_unpacker
	import fwbu_pkg::*;
#(
	parameter int COUNT_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           operation,
	input  logic [7:0]           data_byte,
	output logic                 empty,
	input  logic                 pop,
	output logic [VALUE_W-1:0]   value,
	output logic                 padded,
	output logic                 last_value
);

	cfg_t cfg_q;
	logic cq_full;
	logic cq_push;
	cmd_t cq_in;
	logic cq_empty;
	logic cq_pop;
	cmd_t cq_out;
	logic rq_full;
	logic rq_push;
	res_t rq_in;
	res_t rq_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bits_per_value <= BPV_RESET;
			cfg_q.value_count    <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_BPV: cfg_q.bits_per_value <= wr_data[BPV_W-1:0];
				REG_VC:  cfg_q.value_count    <= wr_data[VC_W-1:0];
			endcase
		end
	end

	fwbu_front u_front (
		.push      (push),
		.operation (operation),
		.data_byte (data_byte),
		.full      (full),
		.q_full    (cq_full),
		.q_push    (cq_push),
		.q_cmd     (cq_in)
	);

	fwbu_fifo #(
		.WIDTH ($bits(cmd_t))
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cq_push),
		.wdata  (cq_in),
		.full   (cq_full),
		.pop    (cq_pop),
		.rdata  (cq_out),
		.empty  (cq_empty)
	);

	fwbu_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cq_empty),
		.cmd       (cq_out),
		.cmd_pop   (cq_pop),
		.res_full  (rq_full),
		.res_push  (rq_push),
		.res       (rq_in)
	);

	fwbu_fifo #(
		.WIDTH ($bits(res_t))
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (rq_in),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_out),
		.empty  (empty)
	);

	assign value      = rq_out.value;
	assign padded     = rq_out.padded;
	assign last_value = rq_out.last_value;

endmodule

// ===== tb/unpack_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unpack_checker
// watches the config port and both queue sides of the unpacker, predicts the
// values each accepted beat yields and compares them with the popped results
// ----------------------------------------------------------------------------
module unpack_checker
	import fwbu_pkg::*;
#(
	parameter int COUNT_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	input  logic                 push,
	input  logic                 full,
	input  logic [1:0]           operation,
	input  logic [7:0]           data_byte,
	input  logic                 empty,
	input  logic                 pop,
	input  logic [VALUE_W-1:0]   value,
	input  logic                 padded,
	input  logic                 last_value,
	output int                   errors,
	output int                   pending
);

	localparam logic [31:0] COUNT_MASK = 32'((64'd1 << COUNT_BITS) - 64'd1);

	// shadow of the block: registers and field state
	logic [BPV_W-1:0] width_reg;
	logic [VC_W-1:0]  count_reg;
	logic [WIN_W-1:0] window;
	int unsigned      held;
	logic [31:0]      emitted;

	res_t expected_values[$];
	res_t head;
	int   mismatches;

	function automatic logic [VALUE_W-1:0] low_ones(input int unsigned w);
		if (w >= VALUE_W) begin
			return '1;
		end
		return (64'd1 << w) - 64'd1;
	endfunction

	task automatic queue_value(input logic [VALUE_W-1:0] v, input logic pad,
		input logic [31:0] cnt);
		res_t r;
		emitted = (emitted + 32'd1) & COUNT_MASK;
		r.value = v;
		r.padded = pad;
		r.last_value = (emitted == cnt);
		expected_values.insert(expected_values.size(), r);
	endtask

	task automatic unpack_beat(input logic [1:0] op, input logic [7:0] data_in);
		logic [31:0]      cnt;
		logic [WIN_W-1:0] shifted;
		int unsigned      w;
		int               n;
		cnt = {8'd0, count_reg} & COUNT_MASK;
		w = (width_reg > 7'd64) ? 64 : int'(width_reg);
		n = 0;
		if (op == OP_START) begin
			window = '0;
			held = 0;
			emitted = '0;
		end else if (emitted < cnt) begin
			if (op == OP_PAD) begin
				queue_value('0, 1'b1, cnt);
			end else if (op == OP_DATA && w != 0) begin
				window = {window[WIN_W-9:0], data_in};
				held += 8;
				// a narrow width can drain at most eight values from one byte
				while (held >= w && emitted < cnt && n < 8) begin
					held -= w;
					// past the low 64 bits only the top byte is seen
					if (held >= VALUE_W) begin
						shifted = {64'd0, (window[WIN_W-1:VALUE_W] >> (held & 32'd7))};
					end else begin
						shifted = window >> held;
					end
					queue_value(shifted[VALUE_W-1:0] & low_ones(w), 1'b0, cnt);
					n++;
				end
				held &= 32'h7F;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = BPV_RESET;
			count_reg = '0;
			window = '0;
			held = 0;
			emitted = '0;
			expected_values.delete();
			mismatches = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_values.size() == 0) begin
					$error("unexpected result beat: value %h padded %b last_value %b",
						value, padded, last_value);
					mismatches++;
				end else begin
					head = expected_values.pop_front();
					if (value !== head.value) begin
						$error("value: expected %h, got %h", head.value, value);
						mismatches++;
					end
					if (padded !== head.padded) begin
						$error("padded: expected %b, got %b", head.padded, padded);
						mismatches++;
					end
					if (last_value !== head.last_value) begin
						$error("last_value: expected %b, got %b", head.last_value, last_value);
						mismatches++;
					end
				end
			end
			if (push && !full) begin
				unpack_beat(operation, data_byte);
			end
			if (wr_en) begin
				case (wr_index)
					REG_BPV: width_reg = wr_data[BPV_W-1:0];
					REG_VC:  count_reg = wr_data[VC_W-1:0];
					default: ;
				endcase
			end
		end
		errors <= mismatches;
		pending <= expected_values.size();
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives the unpacker with directed and random fields of packed bytes,
// pads and starts across many width and count settings; checking is done
// by unpack_checker, this module only makes stimulus and reports
// ----------------------------------------------------------------------------
module tb;
	import fwbu_pkg::*;

	localparam logic [1:0] OP_IGNORED    = 2'd3;
	localparam int         TOTAL_ITEMS   = 450;
	localparam int         SETTLE_CYCLES = 32;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_index = '0;
	logic [CFG_W-1:0]     wr_data = '0;
	logic                 push = 1'b0;
	logic                 full;
	logic [1:0]           operation = OP_START;
	logic [7:0]           data_byte = 8'd0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [VALUE_W-1:0]   value;
	logic                 padded;
	logic                 last_value;
	int                   errors;
	int                   pending;

	int                   burst_left = 0;
	int                   items_sent = 0;

	always #4 clk = ~clk;

	fixed_width_bit_unpacker DUT (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.push(push), .full(full), .operation(operation), .data_byte(data_byte),
		.empty(empty), .pop(pop),
		.value(value), .padded(padded), .last_value(last_value)
	);

	unpack_checker unpack_check (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.push(push), .full(full), .operation(operation), .data_byte(data_byte),
		.empty(empty), .pop(pop),
		.value(value), .padded(padded), .last_value(last_value),
		.errors(errors), .pending(pending)
	);

	// receiver: stall pattern switches now and then between a few modes
	int          pop_mode = 0;
	logic [7:0]  pop_tick = '0;
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) begin
			pop_mode = $urandom_range(0, 3);
		end
		pop_tick++;
		case (pop_mode)
			0: pop <= 1'b1;
			1: pop <= ($urandom_range(0, 9) < 7);
			2: pop <= ($urandom_range(0, 3) == 0);
			default: pop <= pop_tick[3];
		endcase
	end

	task automatic load_format(input logic [CFG_W-1:0] width_word,
		input logic [CFG_W-1:0] count_word);
		wr_en <= 1'b1;
		wr_index <= REG_BPV;
		wr_data <= width_word;
		@(posedge clk);
		wr_index <= REG_VC;
		wr_data <= count_word;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// one beat into the input queue, bursts separated by random gaps
	task automatic feed_op(input logic [1:0] op, input logic [7:0] data_in);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		operation <= op;
		data_byte <= data_in;
		@(posedge clk);
		while (full) @(posedge clk);
		if (op != OP_IGNORED) begin
			items_sent++;
		end
	endtask

	// hold off until every predicted value has been popped, then let
	// result-less beats still in flight retire
	task automatic drain();
		push <= 1'b0;
		// let the checker count the last accepted beat first
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] width_word;
		logic [CFG_W-1:0] count_word;
		int               beats;
		int               pick;
		bit               fresh;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// count is zero out of reset: nothing comes out
		feed_op(OP_DATA, 8'hA5);
		feed_op(OP_PAD, 8'h00);
		drain();

		// width 1: eight values from one byte, then the count runs out
		load_format(24'd1, 24'd9);
		feed_op(OP_START, 8'h00);
		feed_op(OP_DATA, 8'hFF);
		feed_op(OP_DATA, 8'h80);
		feed_op(OP_DATA, 8'h3C);
		drain();

		// width zero: bytes ignored, only pads produce values
		load_format(24'd0, 24'd2);
		feed_op(OP_START, 8'h00);
		feed_op(OP_DATA, 8'hFF);
		feed_op(OP_PAD, 8'hFF);
		feed_op(OP_PAD, 8'h00);
		feed_op(OP_PAD, 8'h00);
		drain();

		// full 64-bit value across the 72-bit window
		load_format(24'd64, 24'd1);
		feed_op(OP_START, 8'h00);
		feed_op(OP_DATA, 8'h80);
		feed_op(OP_DATA, 8'h01);
		feed_op(OP_DATA, 8'hFF);
		feed_op(OP_DATA, 8'h00);
		feed_op(OP_DATA, 8'h55);
		feed_op(OP_DATA, 8'hAA);
		feed_op(OP_DATA, 8'h7F);
		feed_op(OP_DATA, 8'hFE);
		feed_op(OP_IGNORED, 8'hFF);
		drain();

		// largest count, values straddling byte boundaries
		load_format(24'd12, 24'hFFFFFF);
		feed_op(OP_START, 8'h00);
		feed_op(OP_DATA, 8'h00);
		feed_op(OP_DATA, 8'hFF);
		feed_op(OP_DATA, 8'h5A);
		drain();

		while (items_sent < TOTAL_ITEMS) begin
			fresh = ($urandom_range(0, 9) != 0);
			case ($urandom_range(0, 9))
				0: width_word = 24'd0;
				1: width_word = 24'($urandom_range(65, 127));
				2: width_word = 24'd1;
				3: width_word = 24'd64;
				default: width_word = 24'($urandom_range(1, 64));
			endcase
			// junk above the register width is dropped by the block
			if ($urandom_range(0, 3) == 0) begin
				width_word[CFG_W-1:BPV_W] = (CFG_W-BPV_W)'($urandom);
			end
			case ($urandom_range(0, 15))
				0: count_word = 24'd0;
				1: count_word = 24'hFFFFFF;
				2: count_word = 24'($urandom_range(0, 24'hFFFFFF));
				default: count_word = 24'($urandom_range(1, 40));
			endcase
			// mid-field change may drop the count under what was already sent
			if (!fresh && $urandom_range(0, 1) == 0) begin
				count_word = 24'($urandom_range(0, 8));
			end
			load_format(width_word, count_word);
			if (fresh) begin
				feed_op(OP_START, 8'($urandom_range(0, 255)));
			end
			beats = $urandom_range(8, 40);
			repeat (beats) begin
				pick = $urandom_range(0, 99);
				if (pick < 82) begin
					feed_op(OP_DATA, 8'($urandom_range(0, 255)));
				end else if (pick < 92) begin
					feed_op(OP_PAD, 8'($urandom_range(0, 255)));
				end else if (pick < 96) begin
					feed_op(OP_START, 8'($urandom_range(0, 255)));
				end else begin
					feed_op(OP_IGNORED, 8'($urandom_range(0, 255)));
				end
			end
			drain();
		end

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
